// File: rtl/core/dpu_pkg.sv
package dpu_pkg;

   // architectural sizes of the low register file
   localparam int XLEN      = 32;
   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = 3;
   localparam int IMM_W     = 8;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   localparam int DEFAULT_QUEUE_DEPTH = 4;

   // flag bit positions inside nzcv
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_C = 1;
   localparam int FLAG_V = 0;

   // instruction format groups
   localparam logic [2:0] FMT_SHIFT_ADD = 3'b000;
   localparam logic [2:0] FMT_IMM8      = 3'b001;
   localparam logic [5:0] FMT_ALU       = 6'b010000;

   // shift / add-sub group opcodes
   localparam logic [1:0] SH_OP_LSL    = 2'b00;
   localparam logic [1:0] SH_OP_ADDSUB = 2'b11;

   // 8-bit immediate group opcodes
   localparam logic [1:0] IMM_OP_MOV = 2'b00;
   localparam logic [1:0] IMM_OP_CMP = 2'b01;
   localparam logic [1:0] IMM_OP_ADD = 2'b10;
   localparam logic [1:0] IMM_OP_SUB = 2'b11;

   // register alu group opcodes
   localparam logic [3:0] ALU_OP_AND = 4'd0;
   localparam logic [3:0] ALU_OP_EOR = 4'd1;
   localparam logic [3:0] ALU_OP_LSL = 4'd2;
   localparam logic [3:0] ALU_OP_LSR = 4'd3;
   localparam logic [3:0] ALU_OP_ASR = 4'd4;

   // a zero immediate amount on lsr/asr encodes a full-word shift
   localparam logic [IMM_W-1:0] SHIFT_BY_WORD = 8'd32;

   typedef enum logic [2:0] {
      OP_SHIFT,
      OP_ADD,
      OP_SUB,
      OP_MOV,
      OP_AND,
      OP_EOR,
      OP_UNSUP
   } op_class_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2
   } shift_kind_type;

   typedef struct packed {
      op_class_type          op_class;
      shift_kind_type        shift_kind;
      logic                  shift_by_reg;
      logic                  b_is_imm;
      logic [IMM_W-1:0]      imm;
      logic [REG_IDX_W-1:0]  src_a;
      logic [REG_IDX_W-1:0]  src_b;
      logic [REG_IDX_W-1:0]  dest;
      logic                  wr;
   } dpu_op_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic       busy;
      logic [3:0] flags;
   } exec_status_type;

endpackage

// File: rtl/core/dpu_decode.sv
module dpu_decode (
   input  logic [dpu_pkg::REQ_TDATA_W-1:0] instruction,
   output dpu_pkg::dpu_op_type             op
);
   import dpu_pkg::*;

   always_comb begin
      op              = '0;
      op.op_class     = OP_UNSUP;
      op.shift_kind   = SHIFT_LSL;

      if (instruction[15:13] == FMT_SHIFT_ADD) begin
         op.src_a = instruction[5:3];
         op.dest  = instruction[2:0];
         op.wr    = 1'b1;
         if (instruction[12:11] != SH_OP_ADDSUB) begin
            op.op_class   = OP_SHIFT;
            op.shift_kind = shift_kind_type'(instruction[12:11]);
            if (instruction[10:6] == 5'd0 && instruction[12:11] != SH_OP_LSL) begin
               op.imm = SHIFT_BY_WORD;
            end else begin
               op.imm = {3'b000, instruction[10:6]};
            end
         end else begin
            op.op_class = instruction[9] ? OP_SUB : OP_ADD;
            op.src_b    = instruction[8:6];
            op.b_is_imm = instruction[10];
            op.imm      = {5'b00000, instruction[8:6]};
         end
      end else if (instruction[15:13] == FMT_IMM8) begin
         op.src_a    = instruction[10:8];
         op.dest     = instruction[10:8];
         op.b_is_imm = 1'b1;
         op.imm      = instruction[7:0];
         case (instruction[12:11])
            IMM_OP_MOV: begin
               op.op_class = OP_MOV;
               op.wr       = 1'b1;
            end
            IMM_OP_CMP: begin
               op.op_class = OP_SUB;
               op.wr       = 1'b0;
            end
            IMM_OP_ADD: begin
               op.op_class = OP_ADD;
               op.wr       = 1'b1;
            end
            IMM_OP_SUB: begin
               op.op_class = OP_SUB;
               op.wr       = 1'b1;
            end
            default: begin
               op.op_class = OP_UNSUP;
               op.wr       = 1'b0;
            end
         endcase
      end else if (instruction[15:10] == FMT_ALU) begin
         op.src_a = instruction[2:0];
         op.src_b = instruction[5:3];
         op.dest  = instruction[2:0];
         op.wr    = 1'b1;
         case (instruction[9:6])
            ALU_OP_AND: op.op_class = OP_AND;
            ALU_OP_EOR: op.op_class = OP_EOR;
            ALU_OP_LSL: begin
               op.op_class     = OP_SHIFT;
               op.shift_kind   = SHIFT_LSL;
               op.shift_by_reg = 1'b1;
            end
            ALU_OP_LSR: begin
               op.op_class     = OP_SHIFT;
               op.shift_kind   = SHIFT_LSR;
               op.shift_by_reg = 1'b1;
            end
            ALU_OP_ASR: begin
               op.op_class     = OP_SHIFT;
               op.shift_kind   = SHIFT_ASR;
               op.shift_by_reg = 1'b1;
            end
            default: begin
               op.op_class = OP_UNSUP;
               op.wr       = 1'b0;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/dpu_queue.sv
module dpu_queue #(
   parameter int DEPTH = dpu_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  dpu_pkg::dpu_op_type       push_op,
   input  logic                      pop,
   output dpu_pkg::queue_status_type q_status,
   output dpu_pkg::dpu_op_type       head_op
);
   import dpu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dpu_op_type       entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign q_status.valid = (count_ff != '0);
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign head_op        = entries_ff[rd_ptr_ff];

endmodule

// File: rtl/core/dpu_ram.sv
module dpu_ram #(
   parameter int WIDTH = dpu_pkg::XLEN,
   parameter int DEPTH = dpu_pkg::REG_COUNT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: rtl/core/dpu_exec.sv
module dpu_exec (
   input  logic                            clock,
   input  logic                            reset,
   input  dpu_pkg::queue_status_type       q_status,
   input  dpu_pkg::dpu_op_type             head_op,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dpu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,
   output dpu_pkg::exec_status_type        ex_status
);
   import dpu_pkg::*;

   // issue stage signals
   logic                 issue;
   logic                 ex_fire;

   // execute stage registers
   logic                 ex_valid_ff, ex_valid_in;
   dpu_op_type           op_ff;
   logic                 a_fwd_ff, a_fwd_in;
   logic                 b_fwd_ff, b_fwd_in;
   logic                 a_valid_ff, a_valid_in;
   logic                 b_valid_ff, b_valid_in;
   logic [XLEN-1:0]      fwd_val_ff;

   // architectural state
   logic [3:0]           flags_ff, flags_in;
   logic                 reg_valid_ff [REG_COUNT];
   logic                 reg_valid_in [REG_COUNT];

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                 rsp_unsup_ff;

   // register file ports
   logic                 wr_en;
   logic [XLEN-1:0]      rd_data_a;
   logic [XLEN-1:0]      rd_data_b;

   // execute datapath
   logic [XLEN-1:0]      a_op;
   logic [XLEN-1:0]      b_reg;
   logic [XLEN-1:0]      b_op;
   logic [IMM_W-1:0]     amt;
   logic                 over_word;
   logic [5:0]           amt_clamp;
   logic [XLEN:0]        lsl_wide;
   logic [XLEN:0]        lsr_wide;
   logic signed [XLEN:0] asr_src;
   logic [XLEN:0]        asr_wide;
   logic [XLEN-1:0]      shift_r;
   logic                 shift_c;
   logic                 is_sub;
   logic [XLEN-1:0]      sum_b;
   logic [XLEN:0]        sum_wide;
   logic                 sum_ovf;
   logic [XLEN-1:0]      res_val;
   logic                 res_unsup;

   assign ex_fire = ex_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign issue   = q_status.valid && (!ex_valid_ff || ex_fire);
   assign pop     = issue;
   assign wr_en   = ex_fire && op_ff.wr;

   dpu_ram #(
      .WIDTH (XLEN),
      .DEPTH (REG_COUNT)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (op_ff.dest),
      .wr_data   (res_val),
      .rd_en     (issue),
      .rd_addr_a (head_op.src_a),
      .rd_addr_b (head_op.src_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // the instruction in execute writes at the same edge its successor reads
   always_comb begin
      a_fwd_in   = ex_fire && op_ff.wr && (op_ff.dest == head_op.src_a);
      b_fwd_in   = ex_fire && op_ff.wr && (op_ff.dest == head_op.src_b);
      a_valid_in = reg_valid_ff[head_op.src_a];
      b_valid_in = reg_valid_ff[head_op.src_b];
   end

   // operands: forwarded value, stored value, or zero for never-written entries
   always_comb begin
      a_op  = a_fwd_ff ? fwd_val_ff : (a_valid_ff ? rd_data_a : '0);
      b_reg = b_fwd_ff ? fwd_val_ff : (b_valid_ff ? rd_data_b : '0);
      b_op  = op_ff.b_is_imm ? {{(XLEN-IMM_W){1'b0}}, op_ff.imm} : b_reg;
   end

   // barrel shifter, one extra bit catches the carry out
   always_comb begin
      amt       = op_ff.shift_by_reg ? b_reg[IMM_W-1:0] : op_ff.imm;
      over_word = (amt > SHIFT_BY_WORD);
      amt_clamp = over_word ? SHIFT_BY_WORD[5:0] : amt[5:0];
      lsl_wide  = {1'b0, a_op} << amt_clamp;
      lsr_wide  = {a_op, 1'b0} >> amt_clamp;
      asr_src   = {a_op, 1'b0};
      asr_wide  = asr_src >>> amt_clamp;
      case (op_ff.shift_kind)
         SHIFT_LSL: begin
            shift_r = over_word ? '0   : lsl_wide[XLEN-1:0];
            shift_c = over_word ? 1'b0 : lsl_wide[XLEN];
         end
         SHIFT_LSR: begin
            shift_r = over_word ? '0   : lsr_wide[XLEN:1];
            shift_c = over_word ? 1'b0 : lsr_wide[0];
         end
         default: begin
            shift_r = asr_wide[XLEN:1];
            shift_c = asr_wide[0];
         end
      endcase
   end

   // adder, subtract is a + ~b + 1 so carry means no borrow
   always_comb begin
      is_sub   = (op_ff.op_class == OP_SUB);
      sum_b    = is_sub ? ~b_op : b_op;
      sum_wide = {1'b0, a_op} + {1'b0, sum_b} + {{XLEN{1'b0}}, is_sub};
      sum_ovf  = ~(a_op[XLEN-1] ^ sum_b[XLEN-1]) & (a_op[XLEN-1] ^ sum_wide[XLEN-1]);
   end

   always_comb begin
      res_val   = '0;
      res_unsup = 1'b0;
      flags_in  = flags_ff;
      case (op_ff.op_class)
         OP_SHIFT: begin
            res_val = shift_r;
            if (amt != '0) begin
               flags_in[FLAG_C] = shift_c;
            end
         end
         OP_ADD, OP_SUB: begin
            res_val          = sum_wide[XLEN-1:0];
            flags_in[FLAG_C] = sum_wide[XLEN];
            flags_in[FLAG_V] = sum_ovf;
         end
         OP_MOV:   res_val = {{(XLEN-IMM_W){1'b0}}, op_ff.imm};
         OP_AND:   res_val = a_op & b_op;
         OP_EOR:   res_val = a_op ^ b_op;
         default:  res_unsup = 1'b1;
      endcase
      if (!res_unsup) begin
         flags_in[FLAG_N] = res_val[XLEN-1];
         flags_in[FLAG_Z] = (res_val == '0);
      end
   end

   always_comb begin
      ex_valid_in = ex_valid_ff;
      if (issue) begin
         ex_valid_in = 1'b1;
      end else if (ex_fire) begin
         ex_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (ex_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      for (int i = 0; i < REG_COUNT; i++) begin
         reg_valid_in[i] = reg_valid_ff[i] ||
                           (wr_en && (op_ff.dest == REG_IDX_W'(i)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         for (int i = 0; i < REG_COUNT; i++) begin
            reg_valid_ff[i] <= 1'b0;
         end
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ex_fire) begin
            flags_ff <= flags_in;
         end
         for (int i = 0; i < REG_COUNT; i++) begin
            reg_valid_ff[i] <= reg_valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         op_ff      <= head_op;
         a_fwd_ff   <= a_fwd_in;
         b_fwd_ff   <= b_fwd_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         fwd_val_ff <= res_val;
      end
      if (ex_fire) begin
         rsp_data_ff  <= {flags_in,
                          op_ff.wr ? res_val : {XLEN{1'b0}},
                          op_ff.wr ? op_ff.dest : {REG_IDX_W{1'b0}},
                          op_ff.wr};
         rsp_unsup_ff <= res_unsup;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_unsup_ff;
   assign ex_status.busy  = ex_valid_ff;
   assign ex_status.flags = flags_ff;

endmodule

// File: rtl/core/thumb_data_processing_unit_top.sv
// Executes one Thumb-1 data-processing halfword per transfer against eight 32-bit low
// registers and the NZCV flags, returning one response per instruction that reports the
// register write, the resulting flags and whether the encoding is supported. Sustained
// rate is one instruction per clock while responses are accepted. A request is decoded
// into the queue, issued with its register read and executed into the output register.
// The rate is set by the execute stage, which reads two operands, does one add, logic op
// or barrel shift and writes back each cycle, forwarding the previous result so
// dependent instructions run back to back. The register file holds per-entry valid bits
// so it reads as zero right after reset; there is no clearing pass. The request side
// keeps accepting until the QUEUE_DEPTH-entry queue fills, independent of response stalls.
module thumb_data_processing_unit_top #(
   parameter int QUEUE_DEPTH = dpu_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dpu_pkg::REQ_TDATA_W-1:0] req_tdata,   // [15:0] instruction
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dpu_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [0] reg_write, [3:1] dest_reg,
                                                        // [35:4] write_value,
                                                        // [39:36] flags_nzcv
   output logic                            rsp_tuser    // [0] unsupported
);
   import dpu_pkg::*;

   dpu_op_type       dec_op;
   dpu_op_type       head_op;
   queue_status_type q_status;
   exec_status_type  ex_status;
   logic             push;
   logic             pop;

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   dpu_decode u_decode (
      .instruction (req_tdata),
      .op          (dec_op)
   );

   dpu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_op  (dec_op),
      .pop      (pop),
      .q_status (q_status),
      .head_op  (head_op)
   );

   dpu_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .ex_status  (ex_status)
   );

   // a pending response always carries the current architectural flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:36] == ex_status.flags))
      else $error("response flags differ from architectural flags");

   // queued work is issued as soon as the execute stage is free
   assert property (@(posedge clock) disable iff (reset)
      (q_status.valid && !ex_status.busy) |=> ex_status.busy)
      else $error("queued instruction not issued to idle execute stage");

   // no response directly after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule
